// File: hdl/porl_pkg.sv
// shared constants, types and the rank lookup of the priority-ordered request list
`default_nettype none

package porl_pkg;

  // list geometry
  localparam int NUM_IDS    = 61;
  localparam int LIST_DEPTH = 64;
  localparam int ID_W       = 6;
  localparam int RANK_W     = 2;
  localparam int LIST_AW    = $clog2(LIST_DEPTH);
  localparam int LIST_CW    = $clog2(LIST_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int TBL_LO_W   = 64;
  localparam int TBL_HI_W   = 58;
  localparam int TBL_W      = TBL_LO_W + TBL_HI_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_LO = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_HI = 8'd1;

  localparam logic [TBL_LO_W-1:0] TBL_LO_RESET = 64'd57743956246528;
  localparam logic [TBL_HI_W-1:0] TBL_HI_RESET = 58'd281513916628992;

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // one list entry as stored in the memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [RANK_W-1:0] rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // rank of an id from the two packed tables, zero beyond the tables
  function automatic logic [RANK_W-1:0] rank_of(input logic [TBL_LO_W-1:0] lo,
                                                input logic [TBL_HI_W-1:0] hi,
                                                input logic [ID_W-1:0] id);
    logic [TBL_W-1:0] tbl;
    logic [ID_W:0]    bit_pos;
    tbl     = {hi, lo};
    bit_pos = {id, 1'b0};
    if ({1'b0, id} >= (ID_W + 1)'(NUM_IDS)) begin
      return '0;
    end
    return tbl[bit_pos +: RANK_W];
  endfunction

endpackage

`default_nettype wire

// File: hdl/porl_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module porl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/priority_ordered_request_list.sv
// top level of the priority-ordered request list
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o | op_i, lamp_id_i
//   out     | output    | out_valid_o / out_stall_i | head_valid_o, head_id_o, entry_count_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An insert or removal walks the list in the entry ram, one entry per cycle through
// its single read port, from the head to the end of the list. A word that changes
// nothing (bad id, double request, request to a full list, release of an inactive id)
// skips the walk. One word is worked on at a time; the result register holds a
// stalled result while the next word is already accepted.
// Reset clears the list length and active map and reloads the tables; no ram sweep is needed.
`default_nettype none

module priority_ordered_request_list (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          op_i,
  input  wire logic [porl_pkg::ID_W-1:0]     lamp_id_i,
  // result words
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          head_valid_o,
  output      logic [porl_pkg::ID_W-1:0]     head_id_o,
  output      logic [porl_pkg::ID_W-1:0]     entry_count_o,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [porl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [porl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [porl_pkg::LIST_CW-1:0]      k_q, k_d;
  logic [porl_pkg::LIST_CW-1:0]      len_q, len_d;
  logic                              hit_q, hit_d;
  porl_pkg::entry_t                  carry_q, carry_d;
  logic                              op_q;
  logic [porl_pkg::ID_W-1:0]         id_q;
  logic [(1 << porl_pkg::ID_W)-1:0]  active_q, active_d;
  logic [porl_pkg::ID_W-1:0]         head_q;
  logic [porl_pkg::TBL_LO_W-1:0]     tbl_lo_q;
  logic [porl_pkg::TBL_HI_W-1:0]     tbl_hi_q;
  logic                              out_valid_q, out_valid_d;
  logic                              out_head_valid_q;
  logic [porl_pkg::ID_W-1:0]         out_head_id_q;
  logic [porl_pkg::ID_W-1:0]         out_count_q;

  logic                              in_accept;
  logic                              ignore;
  logic                              out_load;
  logic                              ram_we;
  logic [porl_pkg::LIST_AW-1:0]      ram_waddr;
  porl_pkg::entry_t                  ram_wdata;
  logic [porl_pkg::LIST_AW-1:0]      ram_raddr;
  porl_pkg::entry_t                  ram_rdata;
  logic [porl_pkg::ENTRY_W-1:0]      ram_rdata_raw;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // a word that leaves the list untouched
  always_comb begin
    ignore = 1'b0;
    if ({1'b0, lamp_id_i} >= (porl_pkg::ID_W + 1)'(porl_pkg::NUM_IDS)) begin
      ignore = 1'b1;
    end else if (op_i == porl_pkg::OP_REQUEST) begin
      ignore = active_q[lamp_id_i] ||
               (len_q >= porl_pkg::LIST_CW'(porl_pkg::LIST_DEPTH));
    end else begin
      ignore = !active_q[lamp_id_i];
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // walk sequencer: insert shifts entries back, removal shifts them forward
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    len_d     = len_q;
    hit_d     = hit_q;
    carry_d   = carry_q;
    active_d  = active_q;
    ram_we    = 1'b0;
    ram_waddr = k_q[porl_pkg::LIST_AW-1:0];
    ram_wdata = carry_q;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          k_d          = '0;
          hit_d        = 1'b0;
          carry_d.id   = lamp_id_i;
          carry_d.rank = porl_pkg::rank_of(tbl_lo_q, tbl_hi_q, lamp_id_i);
          state_d      = ignore ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        ram_raddr = k_q[porl_pkg::LIST_AW-1:0] + porl_pkg::LIST_AW'(1);
        if (k_q == len_q) begin
          // end of list: append the carried entry or drop the length
          if (op_q == porl_pkg::OP_REQUEST) begin
            ram_we         = 1'b1;
            len_d          = len_q + porl_pkg::LIST_CW'(1);
            active_d[id_q] = 1'b1;
          end else begin
            len_d          = len_q - porl_pkg::LIST_CW'(1);
            active_d[id_q] = 1'b0;
          end
          state_d = ST_DONE;
        end else begin
          if (op_q == porl_pkg::OP_REQUEST) begin
            if (hit_q || (carry_q.rank <= ram_rdata.rank)) begin
              ram_we  = 1'b1;
              carry_d = ram_rdata;
              hit_d   = 1'b1;
            end
          end else begin
            if (hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = k_q[porl_pkg::LIST_AW-1:0] - porl_pkg::LIST_AW'(1);
              ram_wdata = ram_rdata;
            end else if (ram_rdata.id == id_q) begin
              hit_d = 1'b1;
            end
          end
          k_d = k_q + porl_pkg::LIST_CW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      len_q       <= '0;
      hit_q       <= 1'b0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      tbl_lo_q    <= porl_pkg::TBL_LO_RESET;
      tbl_hi_q    <= porl_pkg::TBL_HI_RESET;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      len_q       <= len_d;
      hit_q       <= hit_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == porl_pkg::CFG_PRIO_LO) begin
          tbl_lo_q <= cfg_data_i;
        end else if (cfg_index_i == porl_pkg::CFG_PRIO_HI) begin
          tbl_hi_q <= cfg_data_i[porl_pkg::TBL_HI_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (in_accept) begin
      op_q <= op_i;
      id_q <= lamp_id_i;
    end
    // shadow of entry 0 for the head output
    if (ram_we && (ram_waddr == '0)) begin
      head_q <= ram_wdata.id;
    end
    if (out_load) begin
      out_head_valid_q <= (len_q != '0);
      out_head_id_q    <= (len_q != '0) ? head_q : '0;
      out_count_q      <= len_q[porl_pkg::ID_W-1:0];
    end
  end

  // entry memory
  porl_ram #(
    .WIDTH (porl_pkg::ENTRY_W),
    .DEPTH (porl_pkg::LIST_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = porl_pkg::entry_t'(ram_rdata_raw);

  assign out_valid_o   = out_valid_q;
  assign head_valid_o  = out_head_valid_q;
  assign head_id_o     = out_head_id_q;
  assign entry_count_o = out_count_q;

endmodule

`default_nettype wire

// File: hdl/porl_checker.sv
// port-level checks of the priority-ordered request list
`default_nettype none

module porl_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic                            head_valid_o,
  input wire logic [porl_pkg::ID_W-1:0]       head_id_o,
  input wire logic [porl_pkg::ID_W-1:0]       entry_count_o
);

  // count never passes the number of ids
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, entry_count_o} <= (porl_pkg::ID_W + 1)'(porl_pkg::NUM_IDS)))
    else $error("entry count beyond id range");

  // head flag agrees with the count
  a_head_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (entry_count_o != '0)))
    else $error("head valid disagrees with entry count");

  // empty list shows id zero, a present head is a legal id
  a_head_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o ?
      ({1'b0, head_id_o} < (porl_pkg::ID_W + 1)'(porl_pkg::NUM_IDS)) : (head_id_o == '0)))
    else $error("bad head id");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(head_valid_o) && $stable(head_id_o) && $stable(entry_count_o)))
    else $error("stalled result changed");

endmodule

bind priority_ordered_request_list porl_checker u_porl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .head_valid_o  (head_valid_o),
  .head_id_o     (head_id_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire
